/* rtl/dahps_pkg.sv */
// Shared types, codes and helpers for the dual-axis homing and preset sequencer.
// Used by dahps_cfg_regs, dahps_axis_step and the top level; depends on nothing.
`default_nettype none

package dahps_pkg;

    localparam int SPEED_W     = 23;
    localparam int POS_W       = 32;
    localparam int CMD_W       = 3;
    localparam int PHASE_W     = 5;
    localparam int PHASE_N     = 18;
    localparam int CFG_AW      = 5;
    localparam int CFG_DW      = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 136;

    // host commands; codes six and seven act as no command
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE      = 3'd0,
        CMD_HOME      = 3'd1,
        CMD_READY     = 3'd2,
        CMD_RECEIVE   = 3'd3,
        CMD_PRESQUISH = 3'd4,
        CMD_SQUISH    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_MOVE   = 3'd1,
        ACT_RUN    = 3'd2,
        ACT_ARM    = 3'd3,
        ACT_STOP   = 3'd4,
        ACT_ZERO   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        PRE_NONE      = 2'd0,
        PRE_RECEIVE   = 2'd1,
        PRE_PRESQUISH = 2'd2,
        PRE_SQUISH    = 2'd3
    } preset_t;

    typedef enum logic [2:0] {
        ST_ERROR     = 3'd0,
        ST_SETUP     = 3'd1,
        ST_WAIT_HOME = 3'd2,
        ST_HOMING    = 3'd3,
        ST_WAIT_RDY  = 3'd4,
        ST_IDLE      = 3'd5,
        ST_MOVING    = 3'd6
    } status_t;

    // configuration register indexes, byte address 4*index
    typedef enum logic [2:0] {
        REG_HOME_SPEED  = 3'd0,
        REG_MOVE_SPEED  = 3'd1,
        REG_RECEIVE     = 3'd2,
        REG_PRESQUISH   = 3'd3,
        REG_SQUISH      = 3'd4,
        REG_BACKOFF     = 3'd5,
        REG_LEFT_OFFS   = 3'd6,
        REG_RIGHT_OFFS  = 3'd7
    } reg_idx_t;

    // per-axis phase, one-hot; bit position is the phase code
    typedef enum logic [PHASE_N-1:0] {
        PH_SETUP      = 18'h00001,
        PH_WAIT_HOME  = 18'h00002,
        PH_BACKOFF    = 18'h00004,
        PH_RAMP       = 18'h00008,
        PH_WAIT_STALL = 18'h00010,
        PH_OFFSET     = 18'h00020,
        PH_AT_HOME    = 18'h00040,
        PH_FINISH     = 18'h00080,
        PH_WAIT_READY = 18'h00100,
        PH_STOPPED    = 18'h00200,
        PH_MV_RECV    = 18'h00400,
        PH_AT_RECV    = 18'h00800,
        PH_MV_SQ      = 18'h01000,
        PH_AT_SQ      = 18'h02000,
        PH_MV_PRE     = 18'h04000,
        PH_AT_PRE     = 18'h08000,
        PH_ERROR      = 18'h10000,
        PH_ESTOP      = 18'h20000
    } phase_t;

    typedef struct packed {
        logic [SPEED_W-1:0]      home_speed;
        logic [SPEED_W-1:0]      move_speed;
        logic signed [POS_W-1:0] receive_target;
        logic signed [POS_W-1:0] presquish_target;
        logic signed [POS_W-1:0] squish_target;
        logic signed [POS_W-1:0] backoff_steps;
        logic signed [POS_W-1:0] left_home_offset;
        logic signed [POS_W-1:0] right_home_offset;
    } cfg_t;

    typedef struct packed {
        logic                    cfg_done;
        logic                    in_place;
        logic                    at_speed;
        logic                    stalled;
        logic signed [POS_W-1:0] current_pos;
    } axis_flags_t;

    typedef struct packed {
        action_t                 action;
        logic signed [POS_W-1:0] target;
        logic [SPEED_W-1:0]      speed;
    } axis_out_t;

    // encode a one-hot phase into its phase code
    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] code;
        code = '0;
        for (int i = 0; i < PHASE_N; i++) begin
            if (p[i]) begin
                code = code | PHASE_W'(i);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/dahps_cfg_regs.sv */
// APB-style configuration register file for the sequencer.
// Depends on dahps_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module dahps_cfg_regs
    import dahps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_HOME_SPEED: cfg_next.home_speed        = pwdata[SPEED_W-1:0];
                REG_MOVE_SPEED: cfg_next.move_speed        = pwdata[SPEED_W-1:0];
                REG_RECEIVE:    cfg_next.receive_target    = pwdata;
                REG_PRESQUISH:  cfg_next.presquish_target  = pwdata;
                REG_SQUISH:     cfg_next.squish_target     = pwdata;
                REG_BACKOFF:    cfg_next.backoff_steps     = pwdata;
                REG_LEFT_OFFS:  cfg_next.left_home_offset  = pwdata;
                REG_RIGHT_OFFS: cfg_next.right_home_offset = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_HOME_SPEED: prdata = CFG_DW'(cfg_reg.home_speed);
            REG_MOVE_SPEED: prdata = CFG_DW'(cfg_reg.move_speed);
            REG_RECEIVE:    prdata = cfg_reg.receive_target;
            REG_PRESQUISH:  prdata = cfg_reg.presquish_target;
            REG_SQUISH:     prdata = cfg_reg.squish_target;
            REG_BACKOFF:    prdata = cfg_reg.backoff_steps;
            REG_LEFT_OFFS:  prdata = cfg_reg.left_home_offset;
            REG_RIGHT_OFFS: prdata = cfg_reg.right_home_offset;
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dahps_axis_step.sv */
// Next-phase and motion-action logic for one axis, purely combinational.
// Depends on dahps_pkg; instantiated once per axis by the top level.
`default_nettype none

module dahps_axis_step
    import dahps_pkg::*;
(
    input  wire phase_t             phase,
    input  wire axis_flags_t        flags,
    input  wire cfg_t               cfg,
    input  wire logic signed [POS_W-1:0] home_offset,
    input  wire preset_t            choice,
    input  wire logic               home_cmd,
    input  wire logic               ready_cmd,
    output phase_t                  phase_next,
    output axis_out_t               act
);

    logic      in_recv;
    logic      in_sq;
    logic      in_pre;
    logic      sel_hit;
    phase_t    sel_phase;
    axis_out_t sel_act;

    // preset selection: receive first, then squish, then presquish
    assign in_recv = (phase == PH_MV_RECV) || (phase == PH_AT_RECV);
    assign in_sq   = (phase == PH_MV_SQ)   || (phase == PH_AT_SQ);
    assign in_pre  = (phase == PH_MV_PRE)  || (phase == PH_AT_PRE);

    always_comb begin
        sel_hit   = 1'b1;
        sel_phase = phase;
        sel_act   = '{action: ACT_MOVE, target: cfg.receive_target,
                      speed: cfg.move_speed};
        if (choice == PRE_RECEIVE && !in_recv) begin
            sel_phase = PH_MV_RECV;
        end else if (choice == PRE_SQUISH && !in_sq) begin
            sel_phase = PH_MV_SQ;
            sel_act.target = cfg.squish_target;
        end else if (choice == PRE_PRESQUISH && !in_pre) begin
            sel_phase = PH_MV_PRE;
            sel_act.target = cfg.presquish_target;
        end else begin
            sel_hit = 1'b0;
            sel_act = '{action: ACT_NONE, target: '0, speed: '0};
        end
    end

    // advance the phase
    always_comb begin
        phase_next = phase;
        act        = '{action: ACT_NONE, target: '0, speed: '0};
        case (phase)
            PH_SETUP: begin
                if (flags.cfg_done) phase_next = PH_WAIT_HOME;
            end
            PH_WAIT_HOME: begin
                if (home_cmd) begin
                    act = '{action: ACT_MOVE,
                            target: POS_W'(flags.current_pos + cfg.backoff_steps),
                            speed: cfg.home_speed};
                    phase_next = PH_BACKOFF;
                end
            end
            PH_BACKOFF: begin
                if (flags.in_place) begin
                    act = '{action: ACT_RUN, target: '0, speed: cfg.home_speed};
                    phase_next = PH_RAMP;
                end
            end
            PH_RAMP: begin
                if (flags.at_speed) begin
                    act.action = ACT_ARM;
                    phase_next = PH_WAIT_STALL;
                end
            end
            PH_WAIT_STALL: begin
                if (flags.stalled) begin
                    act.action = ACT_STOP;
                    phase_next = PH_OFFSET;
                end
            end
            PH_OFFSET: begin
                act = '{action: ACT_MOVE, target: home_offset, speed: cfg.home_speed};
                if (flags.in_place) phase_next = PH_AT_HOME;
            end
            PH_AT_HOME: begin
                act.action = ACT_ZERO;
                phase_next = PH_FINISH;
            end
            PH_FINISH: begin
                act = '{action: ACT_MOVE, target: cfg.receive_target,
                        speed: cfg.move_speed};
                if (flags.in_place) phase_next = PH_WAIT_READY;
            end
            PH_WAIT_READY: begin
                if (ready_cmd) phase_next = PH_STOPPED;
            end
            PH_STOPPED, PH_AT_RECV, PH_AT_SQ, PH_AT_PRE: begin
                if (sel_hit) begin
                    act        = sel_act;
                    phase_next = sel_phase;
                end
            end
            PH_MV_RECV, PH_MV_SQ, PH_MV_PRE: begin
                if (flags.in_place) begin
                    if (phase == PH_MV_RECV) phase_next = PH_AT_RECV;
                    else if (phase == PH_MV_SQ) phase_next = PH_AT_SQ;
                    else phase_next = PH_AT_PRE;
                end else if (sel_hit) begin
                    act        = sel_act;
                    phase_next = sel_phase;
                end
            end
            default: begin
                // error and emergency stop hold with no action
                phase_next = phase;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dual_axis_homing_preset_sequencer_top.sv */
// Dual-axis homing and preset sequencer: input word register, per-axis phase
// logic, status rules and a result register. Depends on dahps_pkg,
// dahps_cfg_regs and dahps_axis_step.
// An accepted word passes the input register, then the result register, to m_tdata.
// Throughput: one word per cycle with m_tready high; registers decouple the sides.
// Reset (aresetn low, synchronous): both axes to setup, no preset, status setup,
// configuration registers cleared, both channels empty.
`default_nettype none

module dual_axis_homing_preset_sequencer_top
    import dahps_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // APB configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_AW-1:0]      paddr,
    input  wire logic [CFG_DW-1:0]      pwdata,
    output logic      [CFG_DW-1:0]      prdata,
    output logic                        pready,
    // input words
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // command[2:0], left_cfg_done[3], left_in_place[4], left_at_speed[5],
    // left_stalled[6], left_current_pos[38:7], right_cfg_done[39],
    // right_in_place[40], right_at_speed[41], right_stalled[42],
    // right_current_pos[74:43], zero[79:75]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // result words
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // left_action[2:0], left_target[34:3], left_speed[57:35], right_action[60:58],
    // right_target[92:61], right_speed[115:93], left_phase[120:116],
    // right_phase[125:121], subsystem_status[128:126], zero[135:129]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    typedef struct packed {
        axis_out_t          left_out;
        axis_out_t          right_out;
        logic [PHASE_W-1:0] left_phase;
        logic [PHASE_W-1:0] right_phase;
        status_t            status;
    } result_t;

    cfg_t                  cfg;
    logic                  in_vld_reg, in_vld_next;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic                  out_vld_reg, out_vld_next;
    result_t               out_reg, out_next;
    logic                  advance;

    phase_t                left_phase_reg, left_phase_next;
    phase_t                right_phase_reg, right_phase_next;
    preset_t               preset_reg, preset_next;
    status_t               status_reg, status_next;

    logic [CMD_W-1:0]      cmd;
    axis_flags_t           left_flags, right_flags;
    axis_out_t             left_act, right_act;

    dahps_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: the held word moves on when the result register is free
    assign advance     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready    = !in_vld_reg || advance;
    assign in_vld_next = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    // unpack the held word
    assign cmd = in_data_reg[2:0];
    assign left_flags = '{cfg_done: in_data_reg[3], in_place: in_data_reg[4],
                          at_speed: in_data_reg[5], stalled: in_data_reg[6],
                          current_pos: in_data_reg[38:7]};
    assign right_flags = '{cfg_done: in_data_reg[39], in_place: in_data_reg[40],
                           at_speed: in_data_reg[41], stalled: in_data_reg[42],
                           current_pos: in_data_reg[74:43]};

    // latch the preset choice from the command
    always_comb begin
        case (cmd)
            CMD_RECEIVE:   preset_next = PRE_RECEIVE;
            CMD_PRESQUISH: preset_next = PRE_PRESQUISH;
            CMD_SQUISH:    preset_next = PRE_SQUISH;
            default:       preset_next = preset_reg;
        endcase
    end

    dahps_axis_step u_left (
        .phase       (left_phase_reg),
        .flags       (left_flags),
        .cfg         (cfg),
        .home_offset (cfg.left_home_offset),
        .choice      (preset_next),
        .home_cmd    (cmd == CMD_HOME),
        .ready_cmd   (cmd == CMD_READY),
        .phase_next  (left_phase_next),
        .act         (left_act)
    );

    dahps_axis_step u_right (
        .phase       (right_phase_reg),
        .flags       (right_flags),
        .cfg         (cfg),
        .home_offset (cfg.right_home_offset),
        .choice      (preset_next),
        .home_cmd    (cmd == CMD_HOME),
        .ready_cmd   (cmd == CMD_READY),
        .phase_next  (right_phase_next),
        .act         (right_act)
    );

    // combined status from both new phases; hold when no rule matches
    always_comb begin
        status_next = status_reg;
        if (left_phase_next == PH_ERROR || right_phase_next == PH_ERROR) begin
            status_next = ST_ERROR;
        end else if (left_phase_next == PH_SETUP || right_phase_next == PH_SETUP) begin
            status_next = ST_SETUP;
        end else if (left_phase_next == PH_WAIT_HOME && right_phase_next == PH_WAIT_HOME) begin
            status_next = ST_WAIT_HOME;
        end else if (left_phase_next == PH_BACKOFF || right_phase_next == PH_BACKOFF ||
                     left_phase_next == PH_RAMP || right_phase_next == PH_RAMP ||
                     left_phase_next == PH_WAIT_STALL ||
                     right_phase_next == PH_WAIT_STALL) begin
            status_next = ST_HOMING;
        end else if (left_phase_next == PH_WAIT_READY &&
                     right_phase_next == PH_WAIT_READY) begin
            status_next = ST_WAIT_RDY;
        end else if ((left_phase_next == right_phase_next) &&
                     (left_phase_next == PH_STOPPED || left_phase_next == PH_AT_RECV ||
                      left_phase_next == PH_AT_SQ || left_phase_next == PH_AT_PRE)) begin
            status_next = ST_IDLE;
        end else if (left_phase_next == PH_MV_RECV || right_phase_next == PH_MV_RECV ||
                     left_phase_next == PH_MV_SQ || right_phase_next == PH_MV_SQ ||
                     left_phase_next == PH_MV_PRE || right_phase_next == PH_MV_PRE) begin
            status_next = ST_MOVING;
        end
    end

    // assemble the result word
    always_comb begin
        out_next.left_out    = left_act;
        out_next.right_out   = right_act;
        out_next.left_phase  = phase_code(left_phase_next);
        out_next.right_phase = phase_code(right_phase_next);
        out_next.status      = status_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            left_phase_reg  <= PH_SETUP;
            right_phase_reg <= PH_SETUP;
            preset_reg      <= PRE_NONE;
            status_reg      <= ST_SETUP;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                left_phase_reg  <= left_phase_next;
                right_phase_reg <= right_phase_next;
                preset_reg      <= preset_next;
                status_reg      <= status_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0,
                       out_reg.status,
                       out_reg.right_phase,
                       out_reg.left_phase,
                       out_reg.right_out.speed,
                       out_reg.right_out.target,
                       out_reg.right_out.action,
                       out_reg.left_out.speed,
                       out_reg.left_out.target,
                       out_reg.left_out.action};

`ifndef SYNTHESIS
    // a moved word always shows up as a result next cycle
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("held word advanced but no result appeared");

    // the shown phases match the phase state
    a_phase_match: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_reg.left_phase == phase_code(left_phase_reg) &&
                         out_reg.right_phase == phase_code(right_phase_reg)))
        else $error("result phase differs from phase state");

    // a left idle action carries no target or speed
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_reg.left_out.action == ACT_NONE) |->
            (out_reg.left_out.target == '0 && out_reg.left_out.speed == '0))
        else $error("left idle action with nonzero payload");

    // input is back-pressured only while a word is held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg)
        else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire
